// ===== sv/tlb_lookup_clock_replace_macros.svh =====
// assertion macros for the clock replacement tlb
`ifndef TLB_LOOKUP_CLOCK_REPLACE_MACROS_SVH
`define TLB_LOOKUP_CLOCK_REPLACE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLBCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TLBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tlbcr_pkg.sv =====
// shared types, constants and helpers of the clock replacement tlb
package tlbcr_pkg;

  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // port widths fixed by the interface
  localparam int IN_PAGE_BITS   = 20;
  localparam int IN_FRAME_BITS  = 20;
  localparam int OUT_FRAME_BITS = 20;
  localparam int SLOT_BITS      = 4;

  typedef logic [ENTRIES-1:0]    entry_vec_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOK
  } tlbcr_state_t;

  typedef struct packed {
    logic load_req;   // capture the incoming request
    logic commit;     // look up, update entries, load the result register
    logic out_taken;  // result register drained this cycle
  } tlbcr_cmd_t;

  typedef struct packed {
    logic out_full;   // result register holds an untaken result
  } tlbcr_status_t;

  // index of the lowest set bit, zero when none is set
  function automatic idx_t lowest_idx(entry_vec_t v);
    idx_t idx;
    idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = idx_t'(k);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/tlbcr_ctrl.sv =====
// controller state machine of the clock replacement tlb
module tlbcr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    out_ready,
  input  tlbcr_pkg::tlbcr_status_t status,
  output tlbcr_pkg::tlbcr_cmd_t    cmd
);
  import tlbcr_pkg::*;

  tlbcr_state_t state_r;
  tlbcr_state_t state_nxt;
  logic         out_room;

  assign out_room = !status.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_room) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load_req  = 1'b0;
    cmd.commit    = 1'b0;
    cmd.out_taken = status.out_full && out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_LOOK: begin
        cmd.commit = out_room;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/tlbcr_dp.sv =====
// datapath of the clock replacement tlb: entries, compare, victim pick, result register
module tlbcr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tlbcr_pkg::tlbcr_cmd_t                 cmd,
  output tlbcr_pkg::tlbcr_status_t              status,
  input  logic [tlbcr_pkg::IN_PAGE_BITS-1:0]    in_lookup_page,
  input  logic                                  in_is_write,
  input  logic [tlbcr_pkg::IN_FRAME_BITS-1:0]   in_fill_frame,
  output logic                                  out_valid,
  output logic [tlbcr_pkg::OUT_FRAME_BITS-1:0]  out_frame,
  output logic                                  out_hit,
  output logic [tlbcr_pkg::SLOT_BITS-1:0]       out_slot
);
  import tlbcr_pkg::*;

  // captured request
  page_t  req_page_r;
  logic   req_write_r;
  frame_t req_frame_r;

  // entry storage
  page_t      entry_page_r  [ENTRIES];
  frame_t     entry_frame_r [ENTRIES];
  entry_vec_t entry_valid_r, entry_valid_nxt;
  entry_vec_t entry_used_r,  entry_used_nxt;
  entry_vec_t entry_dirty_r, entry_dirty_nxt;
  logic [31:0] hit_count_r;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_FRAME_BITS-1:0] out_frame_r;
  logic                      out_hit_r;
  logic [SLOT_BITS-1:0]      out_slot_r;

  // lookup and victim
  entry_vec_t match_vec;
  entry_vec_t sweep_clear;
  logic       hit;
  idx_t       hit_idx;
  idx_t       vic_idx;
  idx_t       sel_idx;
  logic       all_valid;
  logic       any_unused;
  idx_t       unused_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_page_r  <= PAGE_BITS'(in_lookup_page);
      req_write_r <= in_is_write;
      req_frame_r <= FRAME_BITS'(in_fill_frame);
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      match_vec[k] = entry_valid_r[k] && (entry_page_r[k] == req_page_r);
    end
  end

  assign hit        = |match_vec;
  assign hit_idx    = lowest_idx(match_vec);
  assign all_valid  = &entry_valid_r;
  assign any_unused = !(&entry_used_r);
  assign unused_idx = lowest_idx(~entry_used_r);

  // clock sweep from entry 0: used bits before the first unused entry are
  // cleared; with no unused entry all are cleared and entry 0 is taken
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      sweep_clear[k] = !any_unused || (idx_t'(k) < unused_idx);
    end
  end

  assign vic_idx = all_valid ? unused_idx : lowest_idx(~entry_valid_r);
  assign sel_idx = hit ? hit_idx : vic_idx;

  always_comb begin
    entry_valid_nxt = entry_valid_r;
    entry_used_nxt  = entry_used_r;
    entry_dirty_nxt = entry_dirty_r;
    if (cmd.commit) begin
      if (hit) begin
        entry_used_nxt[hit_idx] = 1'b1;
        if (req_write_r) begin
          entry_dirty_nxt[hit_idx] = 1'b1;
        end
      end else begin
        if (all_valid) begin
          entry_used_nxt = entry_used_r & ~sweep_clear;
        end
        entry_valid_nxt[vic_idx] = 1'b1;
        entry_used_nxt[vic_idx]  = 1'b1;
        entry_dirty_nxt[vic_idx] = req_write_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (cmd.out_taken) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      entry_used_r  <= '0;
      entry_dirty_r <= '0;
      hit_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
      entry_used_r  <= entry_used_nxt;
      entry_dirty_r <= entry_dirty_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cmd.commit && hit) begin
        hit_count_r <= hit_count_r + 32'd1;
      end
    end
  end

  // entry payload and result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit) begin
        out_frame_r <= OUT_FRAME_BITS'(entry_frame_r[hit_idx]);
      end else begin
        entry_page_r[vic_idx]  <= req_page_r;
        entry_frame_r[vic_idx] <= req_frame_r;
        out_frame_r            <= OUT_FRAME_BITS'(req_frame_r);
      end
      out_hit_r  <= hit;
      out_slot_r <= SLOT_BITS'(sel_idx);
    end
  end

  assign status.out_full = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_frame       = out_frame_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;

endmodule

// ===== sv/tlb_lookup_clock_replace.sv =====
// top level of the fully associative tlb with clock replacement
// Fully associative TLB, 16 entries, clock replacement. Each transfer on the
// input channel is one access: a 20-bit virtual page, a write flag and the
// frame the page table holds for that page. The page is compared against all
// valid entries at once and the lowest-indexed match wins. A hit marks the
// entry used (and dirty on a write), bumps an internal 32-bit hit counter and
// returns the stored frame with hit=1. A miss installs the page and the given
// frame in the lowest-indexed invalid entry; once all entries are valid, a
// clock hand starting at entry 0 clears used bits until it finds an entry that
// was not used, and falls back to entry 0 if every entry was used. The new
// entry starts used, with dirty equal to the write flag, and the given frame
// is returned with hit=0. out_slot names the entry hit or filled. An access is
// handled first in the idle state, which captures the request, and then in the
// look state, which does the parallel compare, victim pick and entry update and
// loads the output register. The next access is taken the cycle after that
// update, so only one access is in flight at a time; a result waiting in the
// output register stalls only the update of the following access. Every entry
// is invalid after reset, with no clearing pass.
`include "tlb_lookup_clock_replace_macros.svh"

module tlb_lookup_clock_replace (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tlbcr_pkg::IN_PAGE_BITS-1:0]    in_lookup_page,
  input  logic                                  in_is_write,
  input  logic [tlbcr_pkg::IN_FRAME_BITS-1:0]   in_fill_frame,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tlbcr_pkg::OUT_FRAME_BITS-1:0]  out_frame,
  output logic                                  out_hit,
  output logic [tlbcr_pkg::SLOT_BITS-1:0]       out_slot
);
  import tlbcr_pkg::*;

  tlbcr_cmd_t    cmd;
  tlbcr_status_t status;

  // sequencing: capture, then look up and commit
  tlbcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // entries, compare and victim logic, output register
  tlbcr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_lookup_page (in_lookup_page),
    .in_is_write    (in_is_write),
    .in_fill_frame  (in_fill_frame),
    .out_valid      (out_valid),
    .out_frame      (out_frame),
    .out_hit        (out_hit),
    .out_slot       (out_slot)
  );

  // one access in flight: no new transfer the cycle after one is taken
  `TLBCR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
                     in_valid && in_ready, !in_ready,
                     "input taken while an access is in flight")

  // a commit never overwrites a result that has not been taken
  `TLBCR_ASSERT_NOW(a_no_result_overwrite, clk, rst_n,
                    cmd.commit, !out_valid || out_ready,
                    "result register overwritten before transfer")

  // a fresh result means the lookup has finished and input is open again
  `TLBCR_ASSERT_NOW(a_ready_with_result, clk, rst_n,
                    $rose(out_valid), in_ready,
                    "result shown while the lookup still runs")

endmodule
